### hw/rtl/serial_link_rx_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Serial link receive decoder assertion macros
// Shared property macros for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINK_RX_DECODER_UNIT_DEFINES_SVH
`define SERIAL_LINK_RX_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define SLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// Serial link receive decoder package
// Link modes, telnet codes, option codes and the break bit position.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam logic [1:0] MODE_TRANSPARENT = 2'd0;
  localparam logic [1:0] MODE_ESCAPE      = 2'd1;
  localparam logic [1:0] MODE_TELNET      = 2'd2;

  localparam logic [7:0] IAC_CODE  = 8'hFF;
  localparam logic [7:0] GA_CODE   = 8'd249;
  localparam logic [7:0] VERB_SB   = 8'd250;
  localparam logic [7:0] VERB_WILL = 8'd251;
  localparam logic [7:0] VERB_WONT = 8'd252;
  localparam logic [7:0] VERB_DO   = 8'd253;
  localparam logic [7:0] VERB_DONT = 8'd254;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;

  localparam int unsigned BREAK_BIT = 2;
  localparam int unsigned FLAG_W    = 6;

endpackage

### hw/rtl/serial_link_rx_decoder_unit.sv
// ----------------------------------------------------------------------------
// Serial link receive decoder
// Decodes received link bytes in transparent, escape or telnet mode.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  rx      | in_valid_i, in_stall_o, rx_byte_i        | in
//  result  | out_valid_o, out_stall_i, result fields  | out
//  config  | cfg_we_i, cfg_wdata_i (link_mode)        | in
//
//  One item per cycle while the result is not stalled; each item passes an
//  input register and then a result register.
//  Reset clears the decode state and flags and sets link_mode to escape.
//  A stalled result holds; the input register still takes one more item,
//  then in_stall_o rises.
// ----------------------------------------------------------------------------
module serial_link_rx_decoder_unit
  import sld_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              data_valid_o,
  output logic [7:0]        data_byte_o,
  output logic              reply_valid_o,
  output logic [7:0]        reply_verb_o,
  output logic [7:0]        reply_option_o,
  output logic              line_valid_o,
  output logic              cts_level_o,
  output logic              dsr_level_o,
  output logic              break_seen_o,
  output logic [FLAG_W-1:0] option_flags_o
);

  logic [1:0]        mode_q;
  logic              s1_valid_q, s1_valid_d;
  logic [7:0]        s1_byte_q;
  logic              out_valid_q, out_valid_d;
  logic              advance;
  logic              in_accept;

  logic              esc_q, esc_d;
  logic              incmd_q, incmd_d;
  logic              hv_q, hv_d;
  logic [7:0]        verb_q, verb_d;
  logic [FLAG_W-1:0] flags_q, flags_d;

  logic              dv, rv, lv, cts, dsr, brk;
  logic [7:0]        db, rverb, ropt;
  logic              opt_known;
  logic [2:0]        opt_bit;
  logic [7:0]        b;

  logic              dv_q, rv_q, lv_q, cts_q, dsr_q, brk_q;
  logic [7:0]        db_q, rverb_q, ropt_q;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  assign b         = s1_byte_q;
  assign opt_known = (b == OPT_BINARY) || (b == OPT_ECHO) || (b == OPT_SGA);
  assign opt_bit   = (b == OPT_BINARY) ? 3'b001 : ((b == OPT_ECHO) ? 3'b010 : 3'b100);

  always_comb begin
    dv      = 1'b0;
    db      = '0;
    rv      = 1'b0;
    rverb   = '0;
    ropt    = '0;
    lv      = 1'b0;
    cts     = 1'b0;
    dsr     = 1'b0;
    brk     = 1'b0;
    esc_d   = esc_q;
    incmd_d = incmd_q;
    hv_d    = hv_q;
    verb_d  = verb_q;
    flags_d = flags_q;
    unique case (mode_q)
      MODE_ESCAPE: begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (b == IAC_CODE) begin
            dv = 1'b1;
            db = IAC_CODE;
          end else begin
            lv  = 1'b1;
            cts = b[0];
            dsr = b[1];
            brk = b[BREAK_BIT];
          end
        end else if (b == IAC_CODE) begin
          esc_d = 1'b1;
        end else begin
          dv = 1'b1;
          db = b;
        end
      end
      MODE_TELNET: begin
        if (!incmd_q) begin
          if (b == IAC_CODE) begin
            incmd_d = 1'b1;
          end else begin
            dv = 1'b1;
            db = b;
          end
        end else if (hv_q) begin
          incmd_d = 1'b0;
          hv_d    = 1'b0;
          if (!opt_known) begin
            if (verb_q > VERB_SB) begin
              rv    = 1'b1;
              rverb = VERB_WONT;
              ropt  = b;
            end
          end else begin
            case (verb_q)
              VERB_WILL: flags_d = flags_q | {3'b000, opt_bit};
              VERB_WONT: flags_d = flags_q & ~{3'b000, opt_bit};
              VERB_DO, VERB_DONT: begin
                rv   = 1'b1;
                ropt = b;
                if (b == OPT_BINARY) begin
                  if (verb_q == VERB_DO) begin
                    flags_d = flags_q | {opt_bit, 3'b000};
                    rverb   = VERB_WILL;
                  end else begin
                    flags_d = flags_q & ~{opt_bit, 3'b000};
                    rverb   = VERB_WONT;
                  end
                end else if (b == OPT_ECHO) begin
                  flags_d = flags_q & ~{opt_bit, 3'b000};
                  rverb   = VERB_WONT;
                end else begin
                  flags_d = flags_q | {opt_bit, 3'b000};
                  rverb   = VERB_WILL;
                end
              end
              default: ;
            endcase
          end
        end else if (b == GA_CODE) begin
          incmd_d = 1'b0;
        end else begin
          verb_d = b;
          hv_d   = 1'b1;
          if (flags_q[0] && (b == IAC_CODE)) begin
            incmd_d = 1'b0;
            hv_d    = 1'b0;
            dv      = 1'b1;
            db      = IAC_CODE;
          end
        end
      end
      default: begin
        dv = 1'b1;
        db = b;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ESCAPE;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      esc_q       <= 1'b0;
      incmd_q     <= 1'b0;
      hv_q        <= 1'b0;
      verb_q      <= '0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (advance) begin
        esc_q   <= esc_d;
        incmd_q <= incmd_d;
        hv_q    <= hv_d;
        verb_q  <= verb_d;
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= rx_byte_i;
    end
    if (advance) begin
      dv_q    <= dv;
      db_q    <= db;
      rv_q    <= rv;
      rverb_q <= rverb;
      ropt_q  <= ropt;
      lv_q    <= lv;
      cts_q   <= cts;
      dsr_q   <= dsr;
      brk_q   <= brk;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_valid_o   = dv_q;
  assign data_byte_o    = db_q;
  assign reply_valid_o  = rv_q;
  assign reply_verb_o   = rverb_q;
  assign reply_option_o = ropt_q;
  assign line_valid_o   = lv_q;
  assign cts_level_o    = cts_q;
  assign dsr_level_o    = dsr_q;
  assign break_seen_o   = brk_q;
  assign option_flags_o = flags_q;

endmodule

### hw/rtl/sld_checker.sv
// ----------------------------------------------------------------------------
// Serial link receive decoder checker
// Port-level properties of the decoder, bound to the decoder module.
// ----------------------------------------------------------------------------
`include "serial_link_rx_decoder_unit_defines.svh"

module sld_checker
  import sld_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              data_valid_o,
  input logic [7:0]        data_byte_o,
  input logic              reply_valid_o,
  input logic [7:0]        reply_verb_o,
  input logic [7:0]        reply_option_o,
  input logic              line_valid_o,
  input logic              cts_level_o,
  input logic              dsr_level_o,
  input logic              break_seen_o,
  input logic [FLAG_W-1:0] option_flags_o
);

  `SLD_ASSERT_NOW(a_reply_verb, out_valid_o && reply_valid_o, (reply_verb_o == VERB_WILL) || (reply_verb_o == VERB_WONT), "reply verb is neither WILL nor WONT")
  `SLD_ASSERT_NOW(a_reply_idle, out_valid_o && !reply_valid_o, (reply_verb_o == 8'd0) && (reply_option_o == 8'd0), "reply fields set without reply")
  `SLD_ASSERT_NOW(a_line_idle, out_valid_o && !line_valid_o, !cts_level_o && !dsr_level_o && !break_seen_o, "line fields set without line update")
  `SLD_ASSERT_NOW(a_one_kind, out_valid_o, $countones({data_valid_o, reply_valid_o, line_valid_o}) <= 1, "more than one result kind in an item")
  `SLD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(data_byte_o) && $stable(option_flags_o), "stalled result changed")

endmodule

bind serial_link_rx_decoder_unit sld_checker u_sld_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial link receive decoder testbench
// Drives received bytes through transparent, escape, telnet and unused link
// modes; some segments add random sender gaps and result stalls. Every item
// is decoded by a local decoder model, each result checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import sld_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         SEG_COUNT      = 12;
  localparam int         SEG_ITEMS      = 95;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         MAX_REPORTS    = 10;

  typedef struct packed {
    logic       drain;
    logic [7:0] value;
  } rx_item_t;

  typedef struct packed {
    logic              data_valid;
    logic [7:0]        data_byte;
    logic              reply_valid;
    logic [7:0]        reply_verb;
    logic [7:0]        reply_option;
    logic              line_valid;
    logic              cts_level;
    logic              dsr_level;
    logic              break_seen;
    logic [FLAG_W-1:0] option_flags;
  } decode_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_wdata_i = MODE_ESCAPE;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              data_valid_o;
  logic [7:0]        data_byte_o;
  logic              reply_valid_o;
  logic [7:0]        reply_verb_o;
  logic [7:0]        reply_option_o;
  logic              line_valid_o;
  logic              cts_level_o;
  logic              dsr_level_o;
  logic              break_seen_o;
  logic [FLAG_W-1:0] option_flags_o;

  rx_item_t       rx_pending_q[$];
  decode_result_t decoded_q[$];
  decode_result_t want;
  rx_item_t       next_item;
  logic           rx_taken = 1'b0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    idle_cycles = 0;

  // decoder model state
  logic [1:0]        mdl_mode = MODE_ESCAPE;
  logic              mdl_esc_pending = 1'b0;
  logic              mdl_in_cmd = 1'b0;
  logic              mdl_have_verb = 1'b0;
  logic [7:0]        mdl_verb = 8'h00;
  logic [FLAG_W-1:0] mdl_flags = '0;

  logic [1:0] seg_mode [SEG_COUNT] = '{
    MODE_TELNET, MODE_ESCAPE, MODE_TRANSPARENT, MODE_UNUSED,
    MODE_TELNET, MODE_ESCAPE, MODE_TELNET, MODE_TRANSPARENT,
    MODE_ESCAPE, MODE_TELNET, MODE_UNUSED, MODE_TELNET
  };

  serial_link_rx_decoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_valid_o   (data_valid_o),
    .data_byte_o    (data_byte_o),
    .reply_valid_o  (reply_valid_o),
    .reply_verb_o   (reply_verb_o),
    .reply_option_o (reply_option_o),
    .line_valid_o   (line_valid_o),
    .cts_level_o    (cts_level_o),
    .dsr_level_o    (dsr_level_o),
    .break_seen_o   (break_seen_o),
    .option_flags_o (option_flags_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic decode_result_t decode_rx_byte(input logic [7:0] b);
    decode_result_t    r;
    logic [FLAG_W-1:0] srv_bit;
    logic [FLAG_W-1:0] cli_bit;
    r = '0;
    case (mdl_mode)
      MODE_ESCAPE: begin
        if (mdl_esc_pending) begin
          mdl_esc_pending = 1'b0;
          if (b == IAC_CODE) begin
            r.data_valid = 1'b1;
            r.data_byte  = IAC_CODE;
          end else begin
            r.line_valid = 1'b1;
            r.cts_level  = b[0];
            r.dsr_level  = b[1];
            r.break_seen = b[BREAK_BIT];
          end
        end else if (b == IAC_CODE) begin
          mdl_esc_pending = 1'b1;
        end else begin
          r.data_valid = 1'b1;
          r.data_byte  = b;
        end
      end
      MODE_TELNET: begin
        if (!mdl_in_cmd) begin
          if (b == IAC_CODE) begin
            mdl_in_cmd = 1'b1;
          end else begin
            r.data_valid = 1'b1;
            r.data_byte  = b;
          end
        end else if (mdl_have_verb) begin
          if (b != OPT_BINARY && b != OPT_ECHO && b != OPT_SGA) begin
            if (mdl_verb > VERB_SB) begin
              r.reply_valid  = 1'b1;
              r.reply_verb   = VERB_WONT;
              r.reply_option = b;
            end
          end else begin
            srv_bit = (b == OPT_BINARY) ? 6'b000001 : (b == OPT_ECHO) ? 6'b000010 : 6'b000100;
            cli_bit = srv_bit << 3;
            case (mdl_verb)
              VERB_WILL: mdl_flags = mdl_flags | srv_bit;
              VERB_WONT: mdl_flags = mdl_flags & ~srv_bit;
              VERB_DO, VERB_DONT: begin
                r.reply_valid  = 1'b1;
                r.reply_option = b;
                if (b == OPT_BINARY && mdl_verb == VERB_DO) begin
                  mdl_flags    = mdl_flags | cli_bit;
                  r.reply_verb = VERB_WILL;
                end else if (b == OPT_BINARY || b == OPT_ECHO) begin
                  mdl_flags    = mdl_flags & ~cli_bit;
                  r.reply_verb = VERB_WONT;
                end else begin
                  mdl_flags    = mdl_flags | cli_bit;
                  r.reply_verb = VERB_WILL;
                end
              end
              default: ;
            endcase
          end
          mdl_in_cmd    = 1'b0;
          mdl_have_verb = 1'b0;
        end else if (b == GA_CODE) begin
          mdl_in_cmd = 1'b0;
        end else begin
          mdl_verb      = b;
          mdl_have_verb = 1'b1;
          if (mdl_flags[0] && b == IAC_CODE) begin
            mdl_in_cmd    = 1'b0;
            mdl_have_verb = 1'b0;
            r.data_valid  = 1'b1;
            r.data_byte   = IAC_CODE;
          end
        end
      end
      default: begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
      end
    endcase
    r.option_flags = mdl_flags;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
    end
  endtask

  task automatic push_item(input logic [7:0] value, input logic drain = 1'b0);
    rx_item_t it;
    it.drain = drain;
    it.value = value;
    rx_pending_q.push_back(it);
  endtask

  function automatic logic [7:0] pick_option();
    if ($urandom_range(0, 99) >= 75) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0:       return OPT_BINARY;
      1:       return OPT_ECHO;
      default: return OPT_SGA;
    endcase
  endfunction

  task automatic gen_sequence(input logic [1:0] mode);
    int unsigned r;
    logic        hold;
    r    = $urandom_range(0, 99);
    hold = ($urandom_range(0, 99) < 2);
    case (mode)
      MODE_ESCAPE: begin
        if (r < 55) begin
          push_item(8'($urandom_range(0, 254)), hold);
        end else if (r < 70) begin
          push_item(IAC_CODE, hold);
          push_item(IAC_CODE);
        end else if (r < 92) begin
          push_item(IAC_CODE, hold);
          push_item(8'($urandom_range(0, 254)));
        end else begin
          push_item(8'($urandom_range(0, 255)), hold);
        end
      end
      MODE_TELNET: begin
        if (r < 25) begin
          push_item(8'($urandom_range(0, 254)), hold);
        end else if (r < 65) begin
          push_item(IAC_CODE, hold);
          push_item(8'($urandom_range(VERB_WILL, VERB_DONT)));
          push_item(pick_option());
        end else if (r < 72) begin
          push_item(IAC_CODE, hold);
          push_item(GA_CODE);
        end else if (r < 80) begin
          push_item(IAC_CODE, hold);
          push_item(IAC_CODE);
        end else if (r < 88) begin
          push_item(IAC_CODE, hold);
          push_item(8'($urandom_range(0, 255)));
          push_item(8'($urandom_range(0, 255)));
        end else begin
          push_item(8'($urandom_range(0, 255)), hold);
        end
      end
      default: begin
        push_item((r < 15) ? IAC_CODE : 8'($urandom_range(0, 255)), hold);
      end
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_pending_q.size() != 0 || in_valid_i || decoded_q.size() != 0);
  endtask

  task automatic write_link_mode(input logic [1:0] mode);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_mode = mode;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || rx_taken)) begin
      if (rx_pending_q.size() == 0 || (rx_pending_q[0].drain && decoded_q.size() != 0) ||
          $urandom_range(0, 99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        next_item = rx_pending_q.pop_front();
        in_valid_i <= 1'b1;
        rx_byte_i  <= next_item.value;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_taken <= 1'b0;
    end else begin
      rx_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with no item outstanding", $time);
        end else begin
          want = decoded_q.pop_front();
          check_field("data_valid", want.data_valid, data_valid_o);
          check_field("data_byte", want.data_byte, data_byte_o);
          check_field("reply_valid", want.reply_valid, reply_valid_o);
          check_field("reply_verb", want.reply_verb, reply_verb_o);
          check_field("reply_option", want.reply_option, reply_option_o);
          check_field("line_valid", want.line_valid, line_valid_o);
          check_field("cts_level", want.cts_level, cts_level_o);
          check_field("dsr_level", want.dsr_level, dsr_level_o);
          check_field("break_seen", want.break_seen, break_seen_o);
          check_field("option_flags", want.option_flags, option_flags_o);
        end
      end
      if (in_valid_i && !in_stall_o) decoded_q.push_back(decode_rx_byte(rx_byte_i));
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned start;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // escape mode out of reset; hold the control byte until the escape drains
    push_item(8'h00);
    push_item(8'h7F);
    push_item(IAC_CODE);
    push_item(8'h07, 1'b1);
    push_item(IAC_CODE);
    push_item(IAC_CODE);
    push_item(8'hFE);

    write_link_mode(MODE_TELNET);
    push_item(8'h41);
    push_item(IAC_CODE);
    push_item(GA_CODE);
    push_item(IAC_CODE);
    push_item(VERB_WILL);
    push_item(OPT_BINARY);
    push_item(IAC_CODE);
    push_item(IAC_CODE);
    push_item(IAC_CODE);
    push_item(VERB_DO);
    push_item(OPT_ECHO);
    push_item(IAC_CODE);
    push_item(VERB_DONT);
    push_item(OPT_SGA);
    push_item(IAC_CODE);
    push_item(VERB_WONT);
    push_item(8'h07);

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      write_link_mode(seg_mode[seg]);
      case (seg / 4)
        0: begin
          send_idle_pct  = 20;
          recv_stall_pct = 63;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      start = rx_pending_q.size();
      while (rx_pending_q.size() - start < SEG_ITEMS) gen_sequence(seg_mode[seg]);
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (decoded_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sld_pkg.sv
hw/rtl/serial_link_rx_decoder_unit.sv
hw/rtl/sld_checker.sv
test/tb_top.sv
